FILE: rtl/pulse_distance_frame_decoder_defines.svh
// assertion macros for the pulse-distance frame decoder
// expects i_clk and i_rst_n in the module that uses them
`ifndef PULSE_DISTANCE_FRAME_DECODER_DEFINES_SVH
`define PULSE_DISTANCE_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, off during reset
`define PDFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdfd assertion failed");

// next-cycle implication, off during reset
`define PDFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdfd assertion failed");

`endif

FILE: rtl/pdfd_pkg.sv
// shared types, constants and window math for the pulse-distance frame decoder
// no dependencies
package pdfd_pkg;

    localparam int FRAME_BITS_DEF = 12;
    localparam int DATA_W         = 12;
    localparam int DUR_W          = 16;
    localparam int TOL_W          = 7;
    localparam int BND_W          = 13;

    localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;
    localparam logic [TOL_W-1:0] TOL_MAX   = 7'd100;

    // nominal lengths are multiples of 100 us, so bounds are k * (100 -/+ t)
    localparam logic [BND_W-1:0] K_HDR  = 13'd30;
    localparam logic [BND_W-1:0] K_UNIT = 13'd10;
    localparam logic [BND_W-1:0] K_ONE  = 13'd20;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_TRAILER
    } t_phase;

    typedef struct packed {
        logic             frame_start;
        logic             is_mark;
        logic [DUR_W-1:0] duration_us;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] data;
    } t_out_item;

    typedef struct packed {
        logic [BND_W-1:0] hdr_lo;
        logic [BND_W-1:0] hdr_hi;
        logic [BND_W-1:0] unit_lo;
        logic [BND_W-1:0] unit_hi;
        logic [BND_W-1:0] one_lo;
        logic [BND_W-1:0] one_hi;
    } t_bounds;

    typedef struct packed {
        logic      emit;
        t_out_item item;
    } t_core_res;

    function automatic t_bounds calc_bounds(logic [TOL_W-1:0] tol);
        logic [BND_W-1:0] t;
        logic [BND_W-1:0] neg;
        logic [BND_W-1:0] pos;
        t_bounds          b;
        t   = (tol > TOL_MAX) ? BND_W'(TOL_MAX) : BND_W'(tol);
        neg = BND_W'(TOL_MAX) - t;
        pos = BND_W'(TOL_MAX) + t;
        b.hdr_lo  = BND_W'(neg * K_HDR);
        b.hdr_hi  = BND_W'(pos * K_HDR);
        b.unit_lo = BND_W'(neg * K_UNIT);
        b.unit_hi = BND_W'(pos * K_UNIT);
        b.one_lo  = BND_W'(neg * K_ONE);
        b.one_hi  = BND_W'(pos * K_ONE);
        return b;
    endfunction

    function automatic logic in_win(logic [DUR_W-1:0] dur, logic [BND_W-1:0] lo,
                                    logic [BND_W-1:0] hi);
        return (dur >= DUR_W'(lo)) && (dur <= DUR_W'(hi));
    endfunction

endpackage

FILE: rtl/pdfd_bounds.sv
// acceptance window registers, recomputed on each tolerance write
// depends on pdfd_pkg
module pdfd_bounds (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [pdfd_pkg::TOL_W-1:0]  i_tol,
    output pdfd_pkg::t_bounds           o_bounds
);
    import pdfd_pkg::*;

    `include "pulse_distance_frame_decoder_defines.svh"

    t_bounds r_bounds;
    t_bounds n_bounds;

    always_comb begin
        n_bounds = i_wr ? calc_bounds(i_tol) : r_bounds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds <= calc_bounds(TOL_RESET);
        end else begin
            r_bounds <= n_bounds;
        end
    end

    assign o_bounds = r_bounds;

    `PDFD_ASSERT_IMP(a_hdr_order, 1'b1, r_bounds.hdr_lo <= r_bounds.hdr_hi)
    `PDFD_ASSERT_IMP(a_unit_order, 1'b1, r_bounds.unit_lo <= r_bounds.unit_hi)
    `PDFD_ASSERT_NXT(a_wr_taken, i_wr, r_bounds == calc_bounds($past(i_tol)))

endmodule

FILE: rtl/pdfd_core.sv
// frame state machine, bit counter and shift word
// depends on pdfd_pkg and the window registers from pdfd_bounds
module pdfd_core #(
    parameter int FRAME_BITS = pdfd_pkg::FRAME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  pdfd_pkg::t_in_item   i_item,
    input  pdfd_pkg::t_bounds    i_bounds,
    output pdfd_pkg::t_core_res  o_res
);
    import pdfd_pkg::*;

    `include "pulse_distance_frame_decoder_defines.svh"

    localparam int CW = $clog2(FRAME_BITS + 1);

    t_phase                r_phase;
    t_phase                n_phase;
    logic [CW-1:0]         r_bits;
    logic [CW-1:0]         n_bits;
    logic [FRAME_BITS-1:0] r_word;
    logic [FRAME_BITS-1:0] n_word;

    t_phase                s_phase;
    logic [CW-1:0]         s_bits;
    logic [FRAME_BITS-1:0] s_word;
    logic                  m_hdr_mark;
    logic                  m_hdr_space;
    logic                  m_bit_mark;
    logic                  m_one;
    logic                  m_zero;
    logic                  m_trail;
    logic [FRAME_BITS+DATA_W-1:0] s_word_ext;

    // frame start restarts at the header mark
    always_comb begin
        s_phase = i_item.frame_start ? PH_HDR_MARK : r_phase;
        s_bits  = i_item.frame_start ? '0 : r_bits;
        s_word  = i_item.frame_start ? '0 : r_word;
    end

    always_comb begin
        m_hdr_mark  = i_item.is_mark
                      && in_win(i_item.duration_us, i_bounds.hdr_lo, i_bounds.hdr_hi);
        m_hdr_space = !i_item.is_mark
                      && in_win(i_item.duration_us, i_bounds.unit_lo, i_bounds.unit_hi);
        m_bit_mark  = i_item.is_mark
                      && in_win(i_item.duration_us, i_bounds.unit_lo, i_bounds.unit_hi);
        m_one       = !i_item.is_mark
                      && in_win(i_item.duration_us, i_bounds.one_lo, i_bounds.one_hi);
        m_zero      = m_hdr_space;
        m_trail     = m_bit_mark;
        s_word_ext  = {{DATA_W{1'b0}}, s_word};
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_bits  = r_bits;
        n_word  = r_word;
        if (i_en) begin
            n_phase = s_phase;
            n_bits  = s_bits;
            n_word  = s_word;
            case (s_phase)
                PH_HDR_MARK: begin
                    n_phase = m_hdr_mark ? PH_HDR_SPACE : PH_IDLE;
                end
                PH_HDR_SPACE: begin
                    n_phase = m_hdr_space ? PH_BIT_MARK : PH_IDLE;
                end
                PH_BIT_MARK: begin
                    n_phase = m_bit_mark ? PH_BIT_SPACE : PH_IDLE;
                end
                PH_BIT_SPACE: begin
                    if (m_one || m_zero) begin
                        n_word  = FRAME_BITS'({s_word, m_one});
                        n_bits  = s_bits + CW'(1);
                        n_phase = (s_bits == CW'(FRAME_BITS - 1)) ? PH_TRAILER : PH_BIT_MARK;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_TRAILER: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res.emit        = 1'b0;
        o_res.item.status = ST_REJECT;
        o_res.item.data   = '0;
        case (s_phase)
            PH_HDR_MARK: begin
                o_res.emit = !m_hdr_mark;
            end
            PH_HDR_SPACE: begin
                o_res.emit = !m_hdr_space;
            end
            PH_BIT_MARK: begin
                o_res.emit = !m_bit_mark;
            end
            PH_BIT_SPACE: begin
                o_res.emit = !(m_one || m_zero);
            end
            PH_TRAILER: begin
                o_res.emit = 1'b1;
                if (m_trail) begin
                    o_res.item.status = ST_OK;
                    o_res.item.data   = s_word_ext[DATA_W-1:0];
                end
            end
            default: begin
                o_res.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bits  <= '0;
            r_word  <= '0;
        end else begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_word  <= n_word;
        end
    end

    `PDFD_ASSERT_IMP(a_reject_zero,
        o_res.emit && (o_res.item.status == ST_REJECT), o_res.item.data == '0)
    `PDFD_ASSERT_NXT(a_emit_idle, i_en && o_res.emit, r_phase == PH_IDLE)
    `PDFD_ASSERT_NXT(a_start_hdr, i_en && i_item.frame_start,
        (r_phase == PH_HDR_SPACE) || (r_phase == PH_IDLE))
    `PDFD_ASSERT_IMP(a_trailer_full, r_phase == PH_TRAILER, r_bits == CW'(FRAME_BITS))

endmodule

FILE: rtl/pulse_distance_frame_decoder.sv
// top level: segment input register, decode core, result register, tolerance port
// depends on pdfd_pkg, pdfd_bounds and pdfd_core
//
// channel   direction  signals                                  payload
// segment   in         i_in_valid, o_in_stall, i_in_item        t_in_item
// result    out        o_out_valid, i_out_stall, o_out_item     t_out_item
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_tolerance_percent
//
// one segment per cycle unless the result register stalls
// segment register -> window compares and state update -> result register
// synchronous active-low reset: idle phase, tolerance 25 percent
// a stalled result holds the segment register, which then stalls the input
module pulse_distance_frame_decoder #(
    parameter int FRAME_BITS = pdfd_pkg::FRAME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  pdfd_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output pdfd_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pdfd_pkg::TOL_W-1:0]  i_cfg_tolerance_percent
);
    import pdfd_pkg::*;

    `include "pulse_distance_frame_decoder_defines.svh"

    logic      r_in_valid;
    logic      n_in_valid;
    t_in_item  r_in_item;
    t_in_item  n_in_item;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic      s_adv;
    logic      s_in_take;
    t_bounds   s_bounds;
    t_core_res s_res;

    assign s_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !s_adv;
    assign s_in_take   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    pdfd_bounds u_bounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid && o_cfg_ready),
        .i_tol    (i_cfg_tolerance_percent),
        .o_bounds (s_bounds)
    );

    pdfd_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s_adv),
        .i_item   (r_in_item),
        .i_bounds (s_bounds),
        .o_res    (s_res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_item  = r_in_item;
        if (s_in_take) begin
            n_in_valid = 1'b1;
            n_in_item  = i_in_item;
        end else if (s_adv) begin
            n_in_valid = 1'b0;
        end
    end

    // result register: loads a result emitted by the core, drains when not stalled
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        if (s_adv && s_res.emit) begin
            n_out_valid = 1'b1;
            n_out_item  = s_res.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
        r_in_item  <= n_in_item;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PDFD_ASSERT_NXT(a_emit_shown, s_adv && s_res.emit, o_out_valid)
    `PDFD_ASSERT_NXT(a_drain, o_out_valid && !i_out_stall && !(s_adv && s_res.emit),
        !o_out_valid)
    `PDFD_ASSERT_NXT(a_take_held, s_in_take, r_in_valid && (r_in_item == $past(i_in_item)))

endmodule
